// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, widths, character codes and command codes of the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int MAX_ROWS    = 50;
  localparam int STORE_CELLS = COLUMNS * MAX_ROWS;

  localparam int ADDR_W     = $clog2(STORE_CELLS);
  localparam int IDX_W      = $clog2(STORE_CELLS + 1);
  localparam int CUR_W      = $clog2(STORE_CELLS + COLUMNS + 1);
  localparam int ROWS_EFF_W = $clog2(MAX_ROWS + 1);

  // row number by reciprocal multiply, one correction step afterwards
  localparam int RECIP_K  = 20;
  localparam int RECIP_M  = (1 << RECIP_K) / COLUMNS;
  localparam int RECIP_MW = $clog2(RECIP_M + 1);
  localparam int PROD_W   = CUR_W + RECIP_MW;

  localparam int KIND_W     = 3;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 12;
  localparam int ROWS_W     = 6;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;
  localparam int OUT_CUR_W  = 12;
  localparam int OUT_DATA_W = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_CUR_W - OUT_DATA_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [ROWS_W-1:0] RESET_ROWS  = 6'd25;
  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;

  localparam logic [CFG_AW-3:0] REG_ROWS = 1'b0;
  localparam logic [CFG_AW-3:0] REG_ATTR = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  typedef logic [2:0] tcw_op_t;

  localparam tcw_op_t OP_NOP     = 3'd0;
  localparam tcw_op_t OP_PUT     = 3'd1;
  localparam tcw_op_t OP_NEWLINE = 3'd2;
  localparam tcw_op_t OP_ERASE   = 3'd3;
  localparam tcw_op_t OP_CLEAR   = 3'd4;
  localparam tcw_op_t OP_SETCUR  = 3'd5;
  localparam tcw_op_t OP_READ    = 3'd6;

  typedef struct packed {
    tcw_op_t           op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
  } tcw_cmd_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } tcw_ctrl_t;

endpackage

// ----- rtl/core/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// Input stage: accepts stream transfers, decodes kind and character into a
// command and holds commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [tcw_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                           cmd_valid,
  output tcw_pkg::tcw_cmd_t              cmd,
  input  tcw_pkg::tcw_ctrl_t             ctrl
);

  tcw_pkg::tcw_cmd_t                q_cmd_r [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             push;
  logic [tcw_pkg::CHAR_W-1:0]       ch;
  tcw_pkg::tcw_cmd_t                dec;

  assign ch = in_tdata[tcw_pkg::CHAR_W-1:0];

  always_comb begin
    dec.ch  = ch;
    dec.pos = in_tdata[tcw_pkg::CHAR_W +: tcw_pkg::POS_W];
    case (in_tuser)
      tcw_pkg::KIND_PUT: begin
        if (ch == tcw_pkg::CH_CR) begin
          dec.op = tcw_pkg::OP_NOP;
        end else if (ch == tcw_pkg::CH_LF) begin
          dec.op = tcw_pkg::OP_NEWLINE;
        end else begin
          dec.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::KIND_ERASE: dec.op = tcw_pkg::OP_ERASE;
      tcw_pkg::KIND_CLEAR: dec.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::KIND_SET:   dec.op = tcw_pkg::OP_SETCUR;
      tcw_pkg::KIND_READ:  dec.op = tcw_pkg::OP_READ;
      default:             dec.op = tcw_pkg::OP_NOP;
    endcase
  end

  assign in_tready = (count_r != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH)) && !ctrl.init_busy;
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_cmd_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (ctrl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (push && !ctrl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && ctrl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r] <= dec;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> count_r != '0)
    else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/core/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// Command sequencer: runs queued commands against the screen store (cell
// writes, newline, scroll, clear, read), keeps the cursor and drives the
// result register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tcw_pkg::ROWS_W-1:0]      cfg_rows,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_attr,
  input  logic                            cmd_valid,
  input  tcw_pkg::tcw_cmd_t               cmd,
  output tcw_pkg::tcw_ctrl_t              ctrl,
  output logic                            ram_we,
  output logic [tcw_pkg::ADDR_W-1:0]      ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]      ram_wdata,
  output logic [tcw_pkg::ADDR_W-1:0]      ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]      ram_rdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LF_BASE = 4'd2;
  localparam logic [3:0] S_LF_ADJ  = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_SCRL    = 4'd5;
  localparam logic [3:0] S_BLANK   = 4'd6;
  localparam logic [3:0] S_CLEAR   = 4'd7;
  localparam logic [3:0] S_RD      = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  localparam logic [tcw_pkg::CUR_W-1:0] COLS_C = tcw_pkg::CUR_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::IDX_W-1:0] COLS_I = tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);

  logic [3:0]                        state_r, state_nxt;
  logic [tcw_pkg::CUR_W-1:0]         cursor_r, cursor_nxt;
  logic [tcw_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [tcw_pkg::CUR_W-1:0]         q_r, q_nxt;
  logic [tcw_pkg::CUR_W-1:0]         base_r, base_nxt;
  logic                              cw_v_r, cw_v_nxt;
  logic [tcw_pkg::ADDR_W-1:0]        cw_a_r, cw_a_nxt;
  logic [tcw_pkg::OUT_DATA_W-1:0]    data_r, data_nxt;
  logic [tcw_pkg::IDX_W-1:0]         span_r, span_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [tcw_pkg::OUT_CUR_W-1:0]     out_cur_r;
  logic [tcw_pkg::OUT_DATA_W-1:0]    out_data_r;
  logic                              load_out;

  logic [tcw_pkg::ROWS_EFF_W-1:0]    rows_eff;
  logic [tcw_pkg::CUR_W-1:0]         span_c;
  logic [tcw_pkg::CUR_W-1:0]         chk_val;
  logic [tcw_pkg::CUR_W-1:0]         chk_back;
  logic [tcw_pkg::CUR_W-1:0]         scroll_cur;
  logic                              need_scroll;
  logic [tcw_pkg::CUR_W-1:0]         cur_dec;
  logic [31:0]                       pos32;
  logic [tcw_pkg::ADDR_W-1:0]        rd_sat;
  logic [tcw_pkg::CUR_W-1:0]         set_cur;
  logic [tcw_pkg::CELL_W-1:0]        blank_word;
  logic [tcw_pkg::PROD_W-1:0]        lf_prod;

  always_comb begin
    if (cfg_rows == '0) begin
      rows_eff = tcw_pkg::ROWS_EFF_W'(1);
    end else if (32'(cfg_rows) > 32'(tcw_pkg::MAX_ROWS)) begin
      rows_eff = tcw_pkg::ROWS_EFF_W'(tcw_pkg::MAX_ROWS);
    end else begin
      rows_eff = tcw_pkg::ROWS_EFF_W'(cfg_rows);
    end
  end

  assign span_nxt   = tcw_pkg::IDX_W'(32'(rows_eff) * 32'(tcw_pkg::COLUMNS));
  assign span_c     = tcw_pkg::CUR_W'(span_r);
  assign blank_word = {cfg_attr, tcw_pkg::CH_SPACE};

  // cursor after the write (put) or as left by newline (check), then scroll fixup
  assign chk_val     = (state_r == S_IDLE) ? cursor_r + 1'b1 : cursor_r;
  assign need_scroll = (chk_val >= span_c);
  assign chk_back    = chk_val - COLS_C;
  assign scroll_cur  = (chk_back >= span_c) ? span_c - 1'b1 : chk_back;

  assign cur_dec = cursor_r - 1'b1;
  assign pos32   = 32'(cmd.pos);
  assign rd_sat  = (pos32 >= 32'(tcw_pkg::STORE_CELLS)) ?
                   tcw_pkg::ADDR_W'(tcw_pkg::STORE_CELLS - 1) : tcw_pkg::ADDR_W'(pos32);
  assign set_cur = (pos32 < 32'(span_r)) ? tcw_pkg::CUR_W'(pos32) : span_c - 1'b1;
  assign lf_prod = tcw_pkg::PROD_W'(cursor_r) * tcw_pkg::PROD_W'(tcw_pkg::RECIP_M);

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    idx_nxt        = idx_r;
    q_nxt          = q_r;
    base_nxt       = base_r;
    cw_v_nxt       = 1'b0;
    cw_a_nxt       = cw_a_r;
    data_nxt       = data_r;
    ram_we         = 1'b0;
    ram_waddr      = tcw_pkg::ADDR_W'(cursor_r);
    ram_wdata      = tcw_pkg::RESET_BLANK;
    ram_raddr      = rd_sat;
    ctrl.pop       = 1'b0;
    ctrl.init_busy = (state_r == S_INIT);
    load_out       = 1'b0;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[tcw_pkg::ADDR_W-1:0];
        if (idx_r == tcw_pkg::IDX_W'(tcw_pkg::STORE_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctrl.pop = 1'b1;
          data_nxt = '0;
          case (cmd.op)
            tcw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_wdata = {cfg_attr, cmd.ch};
              if (need_scroll) begin
                cursor_nxt = scroll_cur;
                idx_nxt    = COLS_I;
                state_nxt  = S_SCRL;
              end else begin
                cursor_nxt = chk_val;
                state_nxt  = S_EMIT;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              q_nxt     = tcw_pkg::CUR_W'(lf_prod >> tcw_pkg::RECIP_K);
              state_nxt = S_LF_BASE;
            end
            tcw_pkg::OP_ERASE: begin
              if (cursor_r != '0) begin
                cursor_nxt = cur_dec;
                ram_we     = 1'b1;
                ram_waddr  = tcw_pkg::ADDR_W'(cur_dec);
                ram_wdata  = blank_word;
              end
              state_nxt = S_EMIT;
            end
            tcw_pkg::OP_CLEAR: begin
              idx_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            tcw_pkg::OP_SETCUR: begin
              cursor_nxt = set_cur;
              state_nxt  = S_EMIT;
            end
            tcw_pkg::OP_READ: begin
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_LF_BASE: begin
        base_nxt  = q_r * COLS_C;
        state_nxt = S_LF_ADJ;
      end
      S_LF_ADJ: begin
        if (cursor_r - base_r >= COLS_C) begin
          cursor_nxt = base_r + COLS_C + COLS_C;
        end else begin
          cursor_nxt = base_r + COLS_C;
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (need_scroll) begin
          cursor_nxt = scroll_cur;
          idx_nxt    = COLS_I;
          state_nxt  = S_SCRL;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SCRL: begin
        // read one row ahead, write the word back one row up in the next cycle
        ram_we    = cw_v_r;
        ram_waddr = cw_a_r;
        ram_wdata = ram_rdata;
        if (idx_r < span_r) begin
          ram_raddr = idx_r[tcw_pkg::ADDR_W-1:0];
          cw_v_nxt  = 1'b1;
          cw_a_nxt  = tcw_pkg::ADDR_W'(idx_r - COLS_I);
          idx_nxt   = idx_r + 1'b1;
        end else if (!cw_v_r) begin
          idx_nxt   = span_r - COLS_I;
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[tcw_pkg::ADDR_W-1:0];
        ram_wdata = blank_word;
        if (idx_r == span_r - 1'b1) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[tcw_pkg::ADDR_W-1:0];
        if (idx_r == span_r - 1'b1) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RD: begin
        data_nxt  = ram_rdata;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cursor_r    <= '0;
      idx_r       <= '0;
      cw_v_r      <= 1'b0;
      span_r      <= tcw_pkg::IDX_W'(32'(tcw_pkg::RESET_ROWS) * 32'(tcw_pkg::COLUMNS));
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      idx_r       <= idx_nxt;
      cw_v_r      <= cw_v_nxt;
      span_r      <= span_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    base_r <= base_nxt;
    cw_a_r <= cw_a_nxt;
    data_r <= data_nxt;
    if (load_out) begin
      out_cur_r  <= tcw_pkg::OUT_CUR_W'(cursor_r);
      out_data_r <= data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{tcw_pkg::OUT_PAD_W{1'b0}}, out_data_r, out_cur_r};

`ifndef SYNTHESIS
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> 32'(ram_waddr) < 32'(tcw_pkg::STORE_CELLS))
    else $error("store write out of range");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_EMIT) |-> 32'(cursor_r) < 32'(tcw_pkg::STORE_CELLS))
    else $error("cursor outside store at rest");

  a_scroll_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCRL |-> idx_r <= span_r && idx_r >= COLS_I)
    else $error("scroll index outside rows in use");
`endif

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text screen engine with cursor, newline, scroll, clear and
// cell read, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// After reset the block fills every cell of the screen store with blanks and
// takes no input transfer meanwhile (register writes are taken). Each input
// transfer gives exactly one result transfer, in order. Newline finds the row
// by reciprocal multiply, corrects it, then checks for a scroll. A scroll and
// clear screen walk the cells of the rows in use, columns times rows, through
// the single write port of the screen store, one cell per cycle. A two-entry
// command queue and the result register let input and output stall
// independently. Registers: rows in use at 0x0, attribute at 0x4; write them
// only while the block is idle.
// ----------------------------------------------------------------------------
module text_console_writer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code, [19:8] position
  input  logic [tcw_pkg::IN_TUSER_W-1:0]  in_tuser,   // [2:0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata,  // [11:0] cursor, [27:12] cell_data
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tcw_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [tcw_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [tcw_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  logic [tcw_pkg::ROWS_W-1:0]  rows_r;
  logic [tcw_pkg::ATTR_W-1:0]  attr_r;
  logic [tcw_pkg::CFG_AW-3:0]  reg_idx;
  logic                        cfg_wr;

  logic                        cmd_valid;
  tcw_pkg::tcw_cmd_t           cmd;
  tcw_pkg::tcw_ctrl_t          ctrl;

  logic                        ram_we;
  logic [tcw_pkg::ADDR_W-1:0]  ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic [tcw_pkg::ADDR_W-1:0]  ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[tcw_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= tcw_pkg::RESET_ROWS;
      attr_r <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wr) begin
      case (reg_idx)
        tcw_pkg::REG_ROWS: rows_r <= cfg_pwdata[tcw_pkg::ROWS_W-1:0];
        tcw_pkg::REG_ATTR: attr_r <= cfg_pwdata[tcw_pkg::ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tcw_pkg::REG_ROWS: cfg_prdata = tcw_pkg::CFG_DW'(rows_r);
      tcw_pkg::REG_ATTR: cfg_prdata = tcw_pkg::CFG_DW'(attr_r);
      default:           cfg_prdata = '0;
    endcase
  end

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctrl      (ctrl)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_rows   (rows_r),
    .cfg_attr   (attr_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .ctrl       (ctrl),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::STORE_CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
